@@ rtl/sfd_pkg.sv @@
package sfd_pkg;

    // Segment geometry: start marker, body bytes and end marker.
    localparam int SEG_LEN = 6;
    // The position counter must hold SEG_LEN itself, reached after the end marker.
    localparam int POS_W   = $clog2(SEG_LEN + 1);

    // Parser phases.
    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_OPEN_ESC  = 3'd1;
    localparam logic [2:0] PH_START     = 3'd2;
    localparam logic [2:0] PH_BODY      = 3'd3;
    localparam logic [2:0] PH_CLOSE_ESC = 3'd4;
    localparam logic [2:0] PH_END       = 3'd5;
    localparam logic [2:0] PH_CHECK     = 3'd6;

    // Result kinds.
    localparam logic [1:0] KIND_SEG    = 2'd0;
    localparam logic [1:0] KIND_ACCEPT = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    // Error codes of a rejected frame.
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_BAD_START = 3'd1;
    localparam logic [2:0] ERR_BODY_ESC  = 3'd2;
    localparam logic [2:0] ERR_BAD_END   = 3'd3;
    localparam logic [2:0] ERR_CHK_ESC   = 3'd4;
    localparam logic [2:0] ERR_CHK_SUM   = 3'd5;

    // Configuration register indexes.
    localparam logic [1:0] REG_ESCAPE = 2'd0;
    localparam logic [1:0] REG_START  = 2'd1;
    localparam logic [1:0] REG_END    = 2'd2;

    typedef logic [7:0] t_byte;

endpackage

@@ rtl/stuffed_frame_decoder_top.sv @@
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_ready    i_rx_byte, i_frame_start
// result    out        o_out_valid / i_out_ready  o_kind, o_seg_byte, o_seg_index, o_error_code
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One item per cycle is taken unless output stalls; any result appears in the next cycle.
// The parser state, position and byte sum update in the accepting cycle itself.
// A stalled result register stops input only while it is full and not taken.
// Reset is synchronous, active low; it restores the default marker codes.
// Configuration writes are always taken and apply from the next item.
module stuffed_frame_decoder_top
    import sfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_frame_start,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_seg_byte,
    output logic [2:0]  o_seg_index,
    output logic [2:0]  o_error_code,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    t_byte             r_escape, r_start, r_end;
    logic [2:0]        r_phase, n_phase;
    logic              r_esc_seen, n_esc_seen;
    logic [POS_W-1:0]  r_pos, n_pos;
    t_byte             r_sum, n_sum;
    logic              r_out_valid;
    logic [1:0]        r_kind, n_kind;
    t_byte             r_seg_byte, n_seg_byte;
    logic [2:0]        r_seg_index, n_seg_index;
    logic [2:0]        r_err, n_err;
    logic              n_has_result;
    logic              in_fire;
    logic [2:0]        cur_phase;
    logic              cur_esc;
    logic [POS_W-1:0]  cur_pos;
    t_byte             cur_sum;
    t_byte             chk;
    logic              emit_seg;
    logic              emit_final;
    logic [2:0]        final_err;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape <= 8'd27;
            r_start  <= 8'd6;
            r_end    <= 8'd3;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ESCAPE: r_escape <= i_cfg_data;
                REG_START:  r_start  <= i_cfg_data;
                REG_END:    r_end    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Parser: one raw byte in, at most one result out.
    always_comb begin
        cur_phase  = i_frame_start ? PH_OPEN_ESC : r_phase;
        cur_esc    = i_frame_start ? 1'b0 : r_esc_seen;
        cur_pos    = i_frame_start ? '0 : r_pos;
        cur_sum    = i_frame_start ? '0 : r_sum;
        chk        = 8'd0 - cur_sum;
        n_phase    = cur_phase;
        n_esc_seen = cur_esc;
        emit_seg   = 1'b0;
        emit_final = 1'b0;
        final_err  = ERR_NONE;

        unique case (cur_phase)
            PH_OPEN_ESC: begin
                if (i_rx_byte != r_escape) begin
                    emit_final = 1'b1;
                    final_err  = ERR_BAD_START;
                end else begin
                    n_phase = PH_START;
                end
            end
            PH_START: begin
                if (i_rx_byte != r_start) begin
                    emit_final = 1'b1;
                    final_err  = ERR_BAD_START;
                end else begin
                    n_phase  = PH_BODY;
                    emit_seg = 1'b1;
                end
            end
            PH_BODY: begin
                if (cur_esc && (i_rx_byte != r_escape)) begin
                    emit_final = 1'b1;
                    final_err  = ERR_BODY_ESC;
                end else if (!cur_esc && (i_rx_byte == r_escape)) begin
                    n_esc_seen = 1'b1;
                end else begin
                    n_esc_seen = 1'b0;
                    emit_seg   = 1'b1;
                    // The position after this byte reaches the end marker slot.
                    if (cur_pos >= POS_W'(SEG_LEN - 2)) begin
                        n_phase = PH_CLOSE_ESC;
                    end
                end
            end
            PH_CLOSE_ESC: begin
                if (i_rx_byte != r_escape) begin
                    emit_final = 1'b1;
                    final_err  = ERR_BAD_END;
                end else begin
                    n_phase = PH_END;
                end
            end
            PH_END: begin
                if (i_rx_byte != r_end) begin
                    emit_final = 1'b1;
                    final_err  = ERR_BAD_END;
                end else begin
                    n_phase    = PH_CHECK;
                    n_esc_seen = 1'b0;
                    emit_seg   = 1'b1;
                end
            end
            PH_CHECK: begin
                if (cur_esc && (i_rx_byte != r_escape)) begin
                    emit_final = 1'b1;
                    final_err  = ERR_CHK_ESC;
                end else if (!cur_esc && (i_rx_byte == r_escape)) begin
                    n_esc_seen = 1'b1;
                end else begin
                    emit_final = 1'b1;
                    final_err  = (chk == i_rx_byte) ? ERR_NONE : ERR_CHK_SUM;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        if (emit_final) begin
            n_phase    = PH_IDLE;
            n_esc_seen = 1'b0;
        end

        n_pos = emit_seg ? cur_pos + 1'b1 : cur_pos;
        n_sum = emit_seg ? cur_sum + i_rx_byte : cur_sum;

        // Result fields.
        n_has_result = emit_seg || emit_final;
        n_kind       = emit_seg ? KIND_SEG
                     : ((final_err == ERR_NONE) ? KIND_ACCEPT : KIND_REJECT);
        n_seg_byte   = emit_seg ? i_rx_byte : 8'd0;
        n_seg_index  = emit_seg ? 3'(cur_pos) : 3'd0;
        n_err        = emit_seg ? ERR_NONE : final_err;
    end

    // Parser state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_esc_seen <= 1'b0;
            r_pos      <= '0;
            r_sum      <= '0;
        end else if (in_fire) begin
            r_phase    <= n_phase;
            r_esc_seen <= n_esc_seen;
            r_pos      <= n_pos;
            r_sum      <= n_sum;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= n_has_result;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && n_has_result) begin
            r_kind      <= n_kind;
            r_seg_byte  <= n_seg_byte;
            r_seg_index <= n_seg_index;
            r_err       <= n_err;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_kind;
    assign o_seg_byte   = r_seg_byte;
    assign o_seg_index  = r_seg_index;
    assign o_error_code = r_err;

    // Checks on the parser and result register.
    a_seg_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_kind == KIND_SEG)) |-> (r_err == ERR_NONE))
        else $error("segment byte carries an error code");

    a_reject_has_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_kind == KIND_REJECT)) |-> (r_err != ERR_NONE))
        else $error("rejected frame without an error code");

    a_idle_no_esc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> !r_esc_seen)
        else $error("pending escape while idle");

    a_body_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BODY) |-> ((r_pos >= POS_W'(1)) && (r_pos <= POS_W'(SEG_LEN - 2))))
        else $error("body position out of range");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_in_ready)
        else $error("input stalled with an empty result register");

endmodule
